FILE: rtl/core/call_profile_accumulator_unit_defines.svh
// Assertion macros shared by the call profile accumulator RTL.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef CALL_PROFILE_ACCUMULATOR_UNIT_DEFINES_SVH
`define CALL_PROFILE_ACCUMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CPA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define CPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/cpa_pkg.sv
// Types and codes of the call profile accumulator.
// Used by call_profile_accumulator_unit, profile_checker and the testbench; depends on nothing.
package cpa_pkg;

    localparam logic [2:0] CMD_BEGIN  = 3'd0;
    localparam logic [2:0] CMD_FINISH = 3'd1;
    localparam logic [2:0] CMD_ENTER  = 3'd2;
    localparam logic [2:0] CMD_LEAVE  = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LV_CALC,
        S_LV_SELF,
        S_SEARCH,
        S_RD_ROW,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] key;
        logic [63:0] self_time;
        logic [63:0] incl_time;
        logic [31:0] calls;
    } row_entry_t;

    typedef struct packed {
        logic [31:0] key;
        logic [63:0] start;
        logic [63:0] child;
    } frame_entry_t;

endpackage

FILE: rtl/core/cpa_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read.
// Depends on nothing; used for the row table and the frame stack.
module cpa_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 160
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/core/call_profile_accumulator_unit.sv
// Call profile accumulator: frame stack and key table in synchronous RAMs.
// Every command passes through S_DONE, which waits for a free output register; a read of a
// filled row adds S_RD_ROW, and a timed leave adds S_LV_CALC, S_LV_SELF and then the
// one-row-per-cycle key search through the row table RAM in S_SEARCH. A new command is
// taken only in S_IDLE, so the unit is busy until the result of the last one is registered.
// Reset (rst_n, asynchronous) clears all status and control; RAMs are not cleared.
module call_profile_accumulator_unit #(
    parameter int ROW_COUNT   = 512,
    parameter int STACK_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [31:0] function_key,
    input  logic [63:0] timestamp,
    input  logic [8:0]  row_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        row_valid,
    output logic [31:0] row_key,
    output logic [63:0] row_self_time,
    output logic [63:0] row_inclusive_time,
    output logic [31:0] row_call_count,
    output logic [9:0]  rows_used,
    output logic [63:0] window_length,
    output logic [63:0] total_self_time,
    output logic [63:0] total_calls,
    output logic        table_overflow,
    output logic        profiling_active
);
`include "call_profile_accumulator_unit_defines.svh"

    localparam int RADDR_W = $clog2(ROW_COUNT);
    localparam int FILL_W  = $clog2(ROW_COUNT + 1);
    localparam int SADDR_W = $clog2(STACK_DEPTH);

    cpa_pkg::state_t state_reg, state_next;

    logic [15:0]        depth_reg, depth_next;
    logic               active_reg, active_next;
    logic               ovf_reg, ovf_next;
    logic [63:0]        wstart_reg, wstart_next;
    logic [63:0]        wcyc_reg, wcyc_next;
    logic [63:0]        self_sum_reg, self_sum_next;
    logic [63:0]        call_sum_reg, call_sum_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [FILL_W-1:0]  issue_reg, issue_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [RADDR_W-1:0] cmp_idx_reg, cmp_idx_next;

    logic [63:0]        ts_reg, ts_next;
    logic [SADDR_W-1:0] sidx_reg, sidx_next;
    logic [31:0]        key_reg, key_next;
    logic [63:0]        incl_reg, incl_next;
    logic [63:0]        child_reg, child_next;
    logic [63:0]        self_reg, self_next;
    logic               rv_reg, rv_next;
    cpa_pkg::row_entry_t res_reg, res_next;

    logic               out_valid_reg, out_valid_next;
    cpa_pkg::row_entry_t o_row_reg, o_row_next;
    logic               o_rv_reg, o_rv_next;
    logic [9:0]         o_used_reg, o_used_next;
    logic [63:0]        o_wcyc_reg, o_wcyc_next;
    logic [63:0]        o_self_reg, o_self_next;
    logic [63:0]        o_calls_reg, o_calls_next;
    logic               o_ovf_reg, o_ovf_next;
    logic               o_act_reg, o_act_next;

    logic                 fr_we;
    logic [SADDR_W-1:0]   fr_waddr, fr_raddr;
    cpa_pkg::frame_entry_t fr_wdata, fr_rdata;
    logic                 rw_we;
    logic [RADDR_W-1:0]   rw_waddr, rw_raddr;
    cpa_pkg::row_entry_t  rw_wdata, rw_rdata;

    logic        accept;
    logic [15:0] depth_dec;
    logic [31:0] fill_ext, idx_ext, issue_ext, depth_ext;
    logic        hit;

    cpa_ram #(.DEPTH(STACK_DEPTH), .WIDTH($bits(cpa_pkg::frame_entry_t))) u_frame_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    cpa_ram #(.DEPTH(ROW_COUNT), .WIDTH($bits(cpa_pkg::row_entry_t))) u_row_ram (
        .clk   (clk),
        .we    (rw_we),
        .waddr (rw_waddr),
        .wdata (rw_wdata),
        .raddr (rw_raddr),
        .rdata (rw_rdata)
    );

    assign in_ready  = (state_reg == cpa_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign depth_dec = depth_reg - 16'd1;
    assign fill_ext  = 32'(fill_reg);
    assign idx_ext   = 32'(row_index);
    assign issue_ext = 32'(issue_reg);
    assign depth_ext = 32'(depth_reg);
    assign hit       = cmp_vld_reg && (rw_rdata.key == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        active_next    = active_reg;
        ovf_next       = ovf_reg;
        wstart_next    = wstart_reg;
        wcyc_next      = wcyc_reg;
        self_sum_next  = self_sum_reg;
        call_sum_next  = call_sum_reg;
        fill_next      = fill_reg;
        issue_next     = issue_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_idx_next   = cmp_idx_reg;
        ts_next        = ts_reg;
        sidx_next      = sidx_reg;
        key_next       = key_reg;
        incl_next      = incl_reg;
        child_next     = child_reg;
        self_next      = self_reg;
        rv_next        = rv_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        o_row_next     = o_row_reg;
        o_rv_next      = o_rv_reg;
        o_used_next    = o_used_reg;
        o_wcyc_next    = o_wcyc_reg;
        o_self_next    = o_self_reg;
        o_calls_next   = o_calls_reg;
        o_ovf_next     = o_ovf_reg;
        o_act_next     = o_act_reg;

        fr_we    = 1'b0;
        fr_waddr = sidx_reg;
        fr_wdata = '0;
        fr_raddr = sidx_reg;
        rw_we    = 1'b0;
        rw_waddr = cmp_idx_reg;
        rw_wdata = '0;
        rw_raddr = issue_ext[RADDR_W-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            cpa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    ts_next    = timestamp;
                    rv_next    = 1'b0;
                    res_next   = '0;
                    state_next = cpa_pkg::S_DONE;
                    case (command)
                        cpa_pkg::CMD_BEGIN:
                        begin
                            fill_next     = '0;
                            depth_next    = '0;
                            self_sum_next = '0;
                            call_sum_next = '0;
                            ovf_next      = 1'b0;
                            wstart_next   = timestamp;
                            active_next   = 1'b1;
                        end
                        cpa_pkg::CMD_FINISH:
                        begin
                            wcyc_next   = timestamp - wstart_reg;
                            active_next = 1'b0;
                        end
                        cpa_pkg::CMD_ENTER:
                        begin
                            if (active_reg)
                            begin
                                if (depth_reg < 16'(STACK_DEPTH))
                                begin
                                    fr_we    = 1'b1;
                                    fr_waddr = depth_ext[SADDR_W-1:0];
                                    fr_wdata = '{key: function_key, start: timestamp,
                                                 child: 64'd0};
                                end
                                if (depth_reg != cpa_pkg::DEPTH_MAX)
                                begin
                                    depth_next = depth_reg + 16'd1;
                                end
                            end
                        end
                        cpa_pkg::CMD_LEAVE:
                        begin
                            if (depth_reg != 16'd0)
                            begin
                                depth_next = depth_dec;
                                // Frames past the stack were never timed.
                                if (depth_dec < 16'(STACK_DEPTH))
                                begin
                                    sidx_next  = depth_dec[SADDR_W-1:0];
                                    fr_raddr   = depth_dec[SADDR_W-1:0];
                                    state_next = cpa_pkg::S_LV_CALC;
                                end
                            end
                        end
                        cpa_pkg::CMD_READ:
                        begin
                            if (idx_ext < fill_ext)
                            begin
                                rw_raddr   = idx_ext[RADDR_W-1:0];
                                state_next = cpa_pkg::S_RD_ROW;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            cpa_pkg::S_LV_CALC:
            begin
                key_next   = fr_rdata.key;
                incl_next  = ts_reg - fr_rdata.start;
                child_next = fr_rdata.child;
                fr_raddr   = sidx_reg - SADDR_W'(1);
                state_next = cpa_pkg::S_LV_SELF;
            end
            cpa_pkg::S_LV_SELF:
            begin
                self_next = (incl_reg > child_reg) ? (incl_reg - child_reg) : 64'd0;
                // The parent word arrived this cycle; charge this call to it.
                if (sidx_reg != '0)
                begin
                    fr_we    = 1'b1;
                    fr_waddr = sidx_reg - SADDR_W'(1);
                    fr_wdata = '{key: fr_rdata.key, start: fr_rdata.start,
                                 child: fr_rdata.child + incl_reg};
                end
                issue_next   = '0;
                cmp_vld_next = 1'b0;
                state_next   = cpa_pkg::S_SEARCH;
            end
            cpa_pkg::S_SEARCH:
            begin
                if (hit)
                begin
                    rw_we         = 1'b1;
                    rw_waddr      = cmp_idx_reg;
                    rw_wdata      = '{key: key_reg,
                                      self_time: rw_rdata.self_time + self_reg,
                                      incl_time: rw_rdata.incl_time + incl_reg,
                                      calls: rw_rdata.calls + 32'd1};
                    self_sum_next = self_sum_reg + self_reg;
                    call_sum_next = call_sum_reg + 64'd1;
                    cmp_vld_next  = 1'b0;
                    state_next    = cpa_pkg::S_DONE;
                end
                else if (!cmp_vld_reg && (issue_reg >= fill_reg))
                begin
                    if (fill_ext >= 32'(ROW_COUNT))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        rw_we     = 1'b1;
                        rw_waddr  = fill_ext[RADDR_W-1:0];
                        rw_wdata  = '{key: key_reg, self_time: self_reg,
                                      incl_time: incl_reg, calls: 32'd1};
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    self_sum_next = self_sum_reg + self_reg;
                    call_sum_next = call_sum_reg + 64'd1;
                    state_next    = cpa_pkg::S_DONE;
                end
                else if (issue_reg < fill_reg)
                begin
                    // One row read issued per cycle; its key is compared next cycle.
                    rw_raddr     = issue_ext[RADDR_W-1:0];
                    cmp_idx_next = issue_ext[RADDR_W-1:0];
                    issue_next   = issue_reg + FILL_W'(1);
                    cmp_vld_next = 1'b1;
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end
            end
            cpa_pkg::S_RD_ROW:
            begin
                rv_next    = 1'b1;
                res_next   = rw_rdata;
                state_next = cpa_pkg::S_DONE;
            end
            cpa_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_row_next     = res_reg;
                    o_rv_next      = rv_reg;
                    o_used_next    = fill_ext[9:0];
                    o_wcyc_next    = wcyc_reg;
                    o_self_next    = self_sum_reg;
                    o_calls_next   = call_sum_reg;
                    o_ovf_next     = ovf_reg;
                    o_act_next     = active_reg;
                    state_next     = cpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpa_pkg::S_IDLE;
            depth_reg     <= '0;
            active_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            wstart_reg    <= '0;
            wcyc_reg      <= '0;
            self_sum_reg  <= '0;
            call_sum_reg  <= '0;
            fill_reg      <= '0;
            issue_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            active_reg    <= active_next;
            ovf_reg       <= ovf_next;
            wstart_reg    <= wstart_next;
            wcyc_reg      <= wcyc_next;
            self_sum_reg  <= self_sum_next;
            call_sum_reg  <= call_sum_next;
            fill_reg      <= fill_next;
            issue_reg     <= issue_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        ts_reg      <= ts_next;
        sidx_reg    <= sidx_next;
        key_reg     <= key_next;
        incl_reg    <= incl_next;
        child_reg   <= child_next;
        self_reg    <= self_next;
        rv_reg      <= rv_next;
        res_reg     <= res_next;
        o_row_reg   <= o_row_next;
        o_rv_reg    <= o_rv_next;
        o_used_reg  <= o_used_next;
        o_wcyc_reg  <= o_wcyc_next;
        o_self_reg  <= o_self_next;
        o_calls_reg <= o_calls_next;
        o_ovf_reg   <= o_ovf_next;
        o_act_reg   <= o_act_next;
    end

    assign out_valid          = out_valid_reg;
    assign row_valid          = o_rv_reg;
    assign row_key            = o_row_reg.key;
    assign row_self_time      = o_row_reg.self_time;
    assign row_inclusive_time = o_row_reg.incl_time;
    assign row_call_count     = o_row_reg.calls;
    assign rows_used          = o_used_reg;
    assign window_length      = o_wcyc_reg;
    assign total_self_time    = o_self_reg;
    assign total_calls        = o_calls_reg;
    assign table_overflow     = o_ovf_reg;
    assign profiling_active   = o_act_reg;

    `CPA_ASSERT_IMPL(a_fill_bound, 1'b1, fill_ext <= 32'(ROW_COUNT))
    `CPA_ASSERT_IMPL(a_issue_bound, state_reg == cpa_pkg::S_SEARCH, issue_reg <= fill_reg)
    `CPA_ASSERT_NEXT(a_accept_busy, accept, state_reg != cpa_pkg::S_IDLE)
    `CPA_ASSERT_NEXT(a_leave_empty,
        accept && (command == cpa_pkg::CMD_LEAVE) && (depth_reg == 16'd0), depth_reg == 16'd0)
endmodule

FILE: tb/profile_checker.sv
// Checker for the call profile accumulator: watches both channels, predicts
// every result word and compares it. Depends on cpa_pkg for the command codes.
module profile_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  command,
    input  logic [31:0] function_key,
    input  logic [63:0] timestamp,
    input  logic [8:0]  row_index,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        row_valid,
    input  logic [31:0] row_key,
    input  logic [63:0] row_self_time,
    input  logic [63:0] row_inclusive_time,
    input  logic [31:0] row_call_count,
    input  logic [9:0]  rows_used,
    input  logic [63:0] window_length,
    input  logic [63:0] total_self_time,
    input  logic [63:0] total_calls,
    input  logic        table_overflow,
    input  logic        profiling_active,
    output int          failures,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS = 512;
    localparam int FRAMES = 128;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [63:0] self_t;
        logic [63:0] incl_t;
        logic [31:0] calls;
        logic [9:0]  used;
        logic [63:0] win;
        logic [63:0] self_total;
        logic [63:0] call_total;
        logic        ovf;
        logic        active;
    } status_word_t;

    logic [31:0] tbl_key [ROWS];
    logic [63:0] tbl_self [ROWS];
    logic [63:0] tbl_incl [ROWS];
    logic [31:0] tbl_calls [ROWS];
    logic [9:0]  fill;
    logic [31:0] stk_key [FRAMES];
    logic [63:0] stk_start [FRAMES];
    logic [63:0] stk_child [FRAMES];
    logic [15:0] depth;
    logic        active, ovf;
    logic [63:0] win_start, win_len, self_total, call_total;

    status_word_t expected_words[$];

    task automatic book_call(input logic [31:0] key, input logic [63:0] s,
                             input logic [63:0] incl);
        for (int i = 0; i < fill; i++)
            if (tbl_key[i] == key)
            begin
                tbl_self[i] += s;
                tbl_incl[i] += incl;
                tbl_calls[i] += 1;
                return;
            end
        if (fill >= ROWS)
        begin
            ovf = 1'b1;
            return;
        end
        tbl_key[fill] = key;
        tbl_self[fill] = s;
        tbl_incl[fill] = incl;
        tbl_calls[fill] = 1;
        fill++;
    endtask

    task automatic predict_word(input logic [2:0] cmd, input logic [31:0] key,
                                input logic [63:0] ts, input logic [8:0] idx);
        status_word_t w;
        logic [63:0] incl, s;
        int d;
        w = '0;
        case (cmd)
            cpa_pkg::CMD_BEGIN:
            begin
                fill = 0; depth = 0; self_total = 0; call_total = 0; ovf = 0;
                win_start = ts; active = 1;
            end
            cpa_pkg::CMD_FINISH:
            begin
                win_len = ts - win_start;
                active = 0;
            end
            cpa_pkg::CMD_ENTER:
                if (active)
                begin
                    if (depth < FRAMES)
                    begin
                        stk_key[depth] = key;
                        stk_child[depth] = 0;
                        stk_start[depth] = ts;
                    end
                    if (depth != 16'hFFFF)
                        depth++;
                end
            cpa_pkg::CMD_LEAVE:
                if (depth != 0)
                begin
                    depth--;
                    d = depth;
                    if (d < FRAMES)
                    begin
                        incl = ts - stk_start[d];
                        s = (incl > stk_child[d]) ? incl - stk_child[d] : 64'd0;
                        if (d > 0)
                            stk_child[d-1] += incl;
                        book_call(stk_key[d], s, incl);
                        self_total += s;
                        call_total += 1;
                    end
                end
            cpa_pkg::CMD_READ:
                if (idx < fill)
                begin
                    w.valid = 1; w.key = tbl_key[idx]; w.self_t = tbl_self[idx];
                    w.incl_t = tbl_incl[idx]; w.calls = tbl_calls[idx];
                end
            default: ;
        endcase
        w.used = fill; w.win = win_len; w.self_total = self_total;
        w.call_total = call_total; w.ovf = ovf; w.active = active;
        expected_words.push_back(w);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        status_word_t got, want;
        if (!rst_n)
        begin
            fill = 0; depth = 0; active = 0; ovf = 0;
            win_start = 0; win_len = 0; self_total = 0; call_total = 0;
            expected_words.delete();
            failures = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{row_valid, row_key, row_self_time, row_inclusive_time,
                        row_call_count, rows_used, window_length, total_self_time,
                        total_calls, table_overflow, profiling_active};
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, got);
                    failures++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got != want)
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        failures++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_word(command, function_key, timestamp, row_index);
        end
        pending = expected_words.size();
    end
endmodule

FILE: tb/testbench.sv
// Top of the call profile accumulator testbench: clock, reset, stimulus and
// verdict. Depends on cpa_pkg, call_profile_accumulator_unit and profile_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk, rst_n;
    logic        in_valid, in_ready, out_valid, out_ready;
    logic [2:0]  command;
    logic [31:0] function_key, row_key, row_call_count;
    logic [63:0] timestamp, row_self_time, row_inclusive_time;
    logic [63:0] window_length, total_self_time, total_calls;
    logic [8:0]  row_index;
    logic [9:0]  rows_used;
    logic        row_valid, table_overflow, profiling_active;
    int          failures, pending;
    int          send_idle, recv_idle, idle_cycles;
    bit          hold_recv;
    logic [63:0] clock_now;

    call_profile_accumulator_unit DUT (.*);
    profile_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Receiver: random stalls, plus one long hold-off while the sender keeps going.
    initial
    begin
        out_ready <= 0;
        forever
        begin
            @(posedge clk);
            out_ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else if (++idle_cycles > 20000)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Valid stays high after an accept until the next word or an idle cycle replaces it.
    task automatic send_word(input logic [2:0] cmd, input logic [31:0] key,
                             input logic [63:0] ts, input logic [8:0] idx);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1; command <= cmd; function_key <= key;
        timestamp <= ts; row_index <= idx;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [63:0] tick();
        clock_now += $urandom_range(40);
        return clock_now;
    endfunction

    // A well-formed burst of nested calls with keys from a small or wide pool.
    task automatic call_tree(input int n, input bit wide);
        int open_calls;
        open_calls = 0;
        for (int i = 0; i < n; i++)
        begin
            if (open_calls > 0 && ($urandom_range(1) || open_calls > 10))
            begin
                send_word(cpa_pkg::CMD_LEAVE, $urandom, tick(), $urandom);
                open_calls--;
            end
            else
            begin
                send_word(cpa_pkg::CMD_ENTER, wide ? $urandom : $urandom_range(12), tick(),
                          $urandom);
                open_calls++;
            end
        end
        while (open_calls-- > 0)
            send_word(cpa_pkg::CMD_LEAVE, $urandom, tick(), $urandom);
    endtask

    initial
    begin
        int phase;
        rst_n = 0; in_valid = 0; command = 0; function_key = 0; timestamp = 0;
        row_index = 0; hold_recv = 0; send_idle = 0; recv_idle = 0; clock_now = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: read on empty table, enter while inactive, leave at depth zero,
        // unused commands, field extremes, backwards time and finish while inactive.
        send_word(cpa_pkg::CMD_READ, 0, 0, 9'd511);
        send_word(cpa_pkg::CMD_ENTER, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_word(cpa_pkg::CMD_LEAVE, 0, 5, 0);
        send_word(3'd5, 0, 0, 0);
        send_word(3'd7, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 9'h1FF);
        send_word(cpa_pkg::CMD_BEGIN, 0, 64'hFFFF_FFFF_FFFF_FFF0, 0);
        send_word(cpa_pkg::CMD_ENTER, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF8, 0);
        send_word(cpa_pkg::CMD_ENTER, 0, 64'd4, 0);
        send_word(cpa_pkg::CMD_LEAVE, 0, 64'd2, 0);
        send_word(cpa_pkg::CMD_LEAVE, 0, 64'd100, 0);
        send_word(cpa_pkg::CMD_READ, 0, 0, 0);
        send_word(cpa_pkg::CMD_READ, 0, 0, 1);
        send_word(cpa_pkg::CMD_READ, 0, 0, 2);
        send_word(cpa_pkg::CMD_FINISH, 0, 64'd200, 0);
        send_word(cpa_pkg::CMD_FINISH, 0, 64'd10, 0);
        send_word(cpa_pkg::CMD_LEAVE, 0, 64'd10, 0);

        // Beyond the frame stack: untimed frames, then unwind them all. Further
        // distinct keys then run the table past its last row. Receiver held off first.
        fork
            begin
                hold_recv = 1;
                repeat (400) @(posedge clk);
                hold_recv = 0;
            end
        join_none
        send_word(cpa_pkg::CMD_BEGIN, 0, tick(), 0);
        for (int i = 0; i < 130; i++)
            send_word(cpa_pkg::CMD_ENTER, 32'h1000 + i, tick(), 0);
        for (int i = 0; i < 130; i++)
            send_word(cpa_pkg::CMD_LEAVE, 0, tick(), 0);
        send_word(cpa_pkg::CMD_READ, 0, 0, 0);
        for (int i = 130; i < 515; i++)
        begin
            send_word(cpa_pkg::CMD_ENTER, 32'h1000 + i, tick(), 0);
            send_word(cpa_pkg::CMD_LEAVE, 0, tick(), 0);
        end
        send_word(cpa_pkg::CMD_READ, 0, 0, 9'd511);
        send_word(cpa_pkg::CMD_READ, 0, 0, 9'd300);
        send_word(cpa_pkg::CMD_ENTER, 32'h1000, tick(), 0);
        send_word(cpa_pkg::CMD_LEAVE, 0, tick(), 0);
        send_word(cpa_pkg::CMD_FINISH, 0, tick(), 0);

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 31 : (phase == 1) ? 88 : 0;
            recv_idle = (phase == 0) ? 88 : (phase == 1) ? 31 : 0;
            send_word(cpa_pkg::CMD_BEGIN, 0, tick(), 0);
            repeat (2)
            begin
                call_tree($urandom_range(6, 16), $urandom_range(3) == 0);
                repeat ($urandom_range(1, 3))
                    send_word(cpa_pkg::CMD_READ, 0, 0, $urandom_range(15));
                // Noise: random commands and fields, some broken sequences.
                repeat ($urandom_range(1, 4))
                    send_word($urandom, $urandom, {$urandom, $urandom}, $urandom);
                if ($urandom_range(3) == 0)
                    send_word(cpa_pkg::CMD_BEGIN, 0, tick(), 0);
            end
            send_word(cpa_pkg::CMD_FINISH, 0, tick(), 0);
        end
        in_valid <= 0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: call_profile_accumulator_unit.f
+incdir+rtl/core
rtl/core/cpa_pkg.sv
rtl/core/cpa_ram.sv
rtl/core/call_profile_accumulator_unit.sv
tb/profile_checker.sv
tb/testbench.sv
